FILE: src/servo_position_ramp_assert.svh
// Assertion macros for the servo position ramp block.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SERVO_POSITION_RAMP_ASSERT_SVH
`define SERVO_POSITION_RAMP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo_position_ramp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo_position_ramp check failed");

`else

`define SRP_ASSERT_IMPL(name, ante, cons)
`define SRP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: src/srp_pkg.sv
// Shared types, constants and helpers for the servo position ramp block.
// No dependencies; imported by every other file of the block but the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

    // Field widths.
    localparam int OPCODE_W = 3;
    localparam int MODE_W   = 2;
    localparam int ANGLE_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W    = 16;
    localparam int FRAC_W   = 8;

    // Parameter defaults.
    localparam int ANGLE_MAX_DEF = 180;
    localparam int STEP_MAX_DEF  = 30;

    // Event opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_APPLY = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_START = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ESTOP = 3'd4;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPEED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMED   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd3;

    // Reset values.
    localparam logic [MODE_W-1:0]     MODE_RESET     = MODE_SPEED;
    localparam logic [ANGLE_W-1:0]    ANGLE_RESET    = 8'd90;
    localparam logic [CFG_DATA_W-1:0] SPEED_RESET    = 16'd5;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_MOVE   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_RESULT = 5'b10000
    } srp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic move;
        logic emit;
    } srp_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic need_move;
        logic has_result;
        logic div_done;
        logic out_free;
    } srp_sts_t;

    function automatic logic [ANGLE_W-1:0] angle_dist(
        input logic [ANGLE_W-1:0] a,
        input logic [ANGLE_W-1:0] b
    );
        angle_dist = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

FILE: src/srp_cmd_if.sv
// Event channel of the servo position ramp: valid/ready plus the event payload.
// Depends on srp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srp_cmd_if
    import srp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic                estop_active;

    modport source (output valid, output opcode, output estop_active, input ready);
    modport sink   (input valid, input opcode, input estop_active, output ready);
endinterface

`default_nettype wire

FILE: src/srp_rsp_if.sv
// Result channel of the servo position ramp: valid/ready plus the result payload.
// Depends on srp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srp_rsp_if
    import srp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] position_deg;
    logic [ANGLE_W-1:0] error_deg;
    logic               running;
    logic               target_reached;
    logic               start_accepted;

    modport source (
        output valid, output position_deg, output error_deg, output running,
        output target_reached, output start_accepted, input ready
    );
    modport sink (
        input valid, input position_deg, input error_deg, input running,
        input target_reached, input start_accepted, output ready
    );
endinterface

`default_nettype wire

FILE: src/srp_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, used for the Q8 step.
// Depends on srp_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module srp_div
    import srp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_sub;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_sub   = rem_shift - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/srp_ctrl.sv
// Sequencing state machine of the servo position ramp.
// Depends on srp_pkg and the assertion macros in servo_position_ramp_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_position_ramp_assert.svh"

module srp_ctrl
    import srp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire srp_sts_t sts,
    output srp_ctl_t      ctl
);
    srp_state_t state_reg;
    srp_state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.need_div)
                begin
                    state_next = ST_DIV;
                end
                else if (sts.need_move)
                begin
                    state_next = ST_MOVE;
                end
                else if (sts.has_result)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                ctl.move   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SRP_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_reg == ST_EXEC)
    `SRP_ASSERT_NEXT(a_div_waits, (state_reg == ST_DIV) && !sts.div_done, state_reg == ST_DIV)
    `SRP_ASSERT_IMPL(a_div_done_in_div, sts.div_done, state_reg == ST_DIV)
    `SRP_ASSERT_NEXT(a_result_holds, (state_reg == ST_RESULT) && !sts.out_free,
                     state_reg == ST_RESULT)

endmodule

`default_nettype wire

FILE: src/srp_dp.sv
// Datapath of the servo position ramp: configuration, plan and position state,
// tick arithmetic, the step divider and the result register. Depends on srp_pkg, srp_div.
`timescale 1ns / 1ps
`default_nettype none

module srp_dp
    import srp_pkg::*;
#(
    parameter int ANGLE_MAX = ANGLE_MAX_DEF,
    parameter int STEP_MAX  = STEP_MAX_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [OPCODE_W-1:0]   in_opcode,
    input  wire logic                  in_estop,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic      [ANGLE_W-1:0]    out_position,
    output logic      [ANGLE_W-1:0]    out_error,
    output logic                       out_running,
    output logic                       out_reached,
    output logic                       out_accepted,
    input  wire srp_ctl_t              ctl,
    output srp_sts_t                   sts
);
    localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(ANGLE_MAX);
    localparam logic [TICKS_W-1:0] STEP_LIM  = TICKS_W'(STEP_MAX);

    // Configuration registers.
    logic [MODE_W-1:0]  mode_cfg_reg;
    logic [ANGLE_W-1:0] setpoint_cfg_reg;
    logic [TICKS_W-1:0] ticks_cfg_reg;
    logic [TICKS_W-1:0] speed_cfg_reg;

    // Latched event.
    logic [OPCODE_W-1:0] op_reg;
    logic                estop_reg;

    // Plan and position state.
    logic [ANGLE_W-1:0] position_reg;
    logic [ANGLE_W-1:0] target_reg;
    logic               run_reg;
    logic [MODE_W-1:0]  amode_reg;
    logic [ANGLE_W-1:0] speed_step_reg;
    logic [TICKS_W-1:0] total_reg;
    logic [TICKS_W-1:0] elapsed_reg;
    logic [DIV_W-1:0]   frac_step_reg;
    logic [FRAC_W-1:0]  accum_reg;

    // Per-event working registers.
    logic [ANGLE_W-1:0] step_amt_reg;
    logic               snap_reg;
    logic               reached_reg;
    logic               accepted_reg;

    // Result register.
    logic               rsp_valid_reg;
    logic [ANGLE_W-1:0] rsp_pos_reg;
    logic [ANGLE_W-1:0] rsp_err_reg;
    logic               rsp_run_reg;
    logic               rsp_reached_reg;
    logic               rsp_acc_reg;

    // Event decode.
    logic [MODE_W-1:0]  mode_eff;
    logic               bad_mode;
    logic               cfg_ok;
    logic [ANGLE_W-1:0] delta_new;
    logic [ANGLE_W-1:0] speed_norm;
    logic               is_cfg_op;
    logic [DIV_W-1:0]   frac_sum;
    logic [ANGLE_W-1:0] whole;
    logic [TICKS_W-1:0] elapsed_inc;

    // Move arithmetic.
    logic [ANGLE_W-1:0] remain;
    logic [ANGLE_W-1:0] move_amt;
    logic [ANGLE_W-1:0] new_pos;

    // Divider.
    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    always_comb
    begin
        mode_eff   = (mode_cfg_reg == MODE_DEFAULT) ? MODE_SPEED : mode_cfg_reg;
        bad_mode   = (mode_cfg_reg == MODE_INVALID);
        cfg_ok     = !bad_mode && (setpoint_cfg_reg <= ANGLE_LIM) &&
                     !((mode_eff == MODE_TIMED) && (ticks_cfg_reg == '0));
        delta_new  = angle_dist(setpoint_cfg_reg, position_reg);
        if (speed_cfg_reg == '0)
        begin
            speed_norm = ANGLE_W'(1);
        end
        else if (speed_cfg_reg > STEP_LIM)
        begin
            speed_norm = STEP_LIM[ANGLE_W-1:0];
        end
        else
        begin
            speed_norm = speed_cfg_reg[ANGLE_W-1:0];
        end
        is_cfg_op   = (op_reg == OP_APPLY) || (op_reg == OP_START);
        frac_sum    = {{(DIV_W-FRAC_W){1'b0}}, accum_reg} + frac_step_reg;
        whole       = (frac_sum[DIV_W-1:FRAC_W] == '0) ? ANGLE_W'(1)
                                                      : frac_sum[DIV_W-1:FRAC_W];
        elapsed_inc = elapsed_reg + 1'b1;

        remain   = angle_dist(position_reg, target_reg);
        move_amt = (step_amt_reg > remain) ? remain : step_amt_reg;
        if (snap_reg)
        begin
            new_pos = target_reg;
        end
        else if (target_reg >= position_reg)
        begin
            new_pos = position_reg + move_amt;
        end
        else
        begin
            new_pos = position_reg - move_amt;
        end

        sts.need_div   = is_cfg_op && cfg_ok && (mode_eff == MODE_TIMED) && (delta_new != '0);
        sts.need_move  = (op_reg == OP_TICK) && run_reg && !estop_reg &&
                         ((amode_reg == MODE_SPEED) || (amode_reg == MODE_TIMED));
        sts.has_result = ((op_reg == OP_TICK) && run_reg) || is_cfg_op ||
                         (op_reg == OP_STOP) || (op_reg == OP_ESTOP);
        sts.div_done   = div_done;
        sts.out_free   = !rsp_valid_reg || out_ready;

        div_start = ctl.exec && sts.need_div;
    end

    srp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({delta_new, {FRAC_W{1'b0}}}),
        .divisor  (ticks_cfg_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg     <= MODE_RESET;
            setpoint_cfg_reg <= ANGLE_RESET;
            ticks_cfg_reg    <= '0;
            speed_cfg_reg    <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MODE:     mode_cfg_reg     <= cfg_wdata[MODE_W-1:0];
                CFG_SETPOINT: setpoint_cfg_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_TICKS:    ticks_cfg_reg    <= cfg_wdata[TICKS_W-1:0];
                CFG_SPEED:    speed_cfg_reg    <= cfg_wdata[TICKS_W-1:0];
                default:      mode_cfg_reg     <= mode_cfg_reg;
            endcase
        end
    end

    // Event capture.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg    <= in_opcode;
            estop_reg <= in_estop;
        end
    end

    // Plan, position and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= ANGLE_RESET;
            target_reg     <= ANGLE_RESET;
            run_reg        <= 1'b0;
            amode_reg      <= MODE_SPEED;
            speed_step_reg <= '0;
            total_reg      <= '0;
            elapsed_reg    <= '0;
            frac_step_reg  <= '0;
            accum_reg      <= '0;
            step_amt_reg   <= '0;
            snap_reg       <= 1'b0;
            reached_reg    <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                reached_reg  <= 1'b0;
                accepted_reg <= 1'b0;
                case (op_reg) inside
                    OP_TICK:
                    begin
                        if (run_reg)
                        begin
                            if (estop_reg)
                            begin
                                run_reg <= 1'b0;
                            end
                            else if (amode_reg == MODE_SPEED)
                            begin
                                step_amt_reg <= speed_step_reg;
                                snap_reg     <= 1'b0;
                            end
                            else if (amode_reg == MODE_TIMED)
                            begin
                                if (position_reg == target_reg)
                                begin
                                    step_amt_reg <= '0;
                                    snap_reg     <= 1'b0;
                                end
                                else if (elapsed_reg >= total_reg)
                                begin
                                    step_amt_reg <= '0;
                                    snap_reg     <= 1'b1;
                                end
                                else
                                begin
                                    elapsed_reg  <= elapsed_inc;
                                    accum_reg    <= frac_sum[FRAC_W-1:0];
                                    step_amt_reg <= whole;
                                    snap_reg     <= (elapsed_inc >= total_reg);
                                end
                            end
                            else
                            begin
                                run_reg <= 1'b0;
                            end
                        end
                    end
                    OP_APPLY, OP_START:
                    begin
                        if (!bad_mode)
                        begin
                            amode_reg <= mode_eff;
                        end
                        if (cfg_ok)
                        begin
                            // Replan from the current position.
                            target_reg     <= setpoint_cfg_reg;
                            speed_step_reg <= (mode_eff == MODE_SPEED) ? speed_norm : '0;
                            total_reg      <= (mode_eff == MODE_TIMED) ? ticks_cfg_reg : '0;
                            elapsed_reg    <= '0;
                            accum_reg      <= '0;
                            frac_step_reg  <= '0;
                        end
                        if (op_reg == OP_START)
                        begin
                            run_reg      <= cfg_ok;
                            accepted_reg <= cfg_ok;
                        end
                    end
                    OP_STOP, OP_ESTOP:
                    begin
                        run_reg <= 1'b0;
                    end
                    default:
                    begin
                        run_reg <= run_reg;
                    end
                endcase
            end

            if (div_done)
            begin
                frac_step_reg <= (div_quo == '0) ? DIV_W'(1) : div_quo;
            end

            if (ctl.move)
            begin
                position_reg <= new_pos;
                if (run_reg && (new_pos == target_reg))
                begin
                    run_reg     <= 1'b0;
                    reached_reg <= 1'b1;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_pos_reg     <= position_reg;
            rsp_err_reg     <= remain;
            rsp_run_reg     <= run_reg;
            rsp_reached_reg <= reached_reg;
            rsp_acc_reg     <= accepted_reg;
        end
    end

    assign out_valid    = rsp_valid_reg;
    assign out_position = rsp_pos_reg;
    assign out_error    = rsp_err_reg;
    assign out_running  = rsp_run_reg;
    assign out_reached  = rsp_reached_reg;
    assign out_accepted = rsp_acc_reg;

endmodule

`default_nettype wire

FILE: src/servo_position_ramp.sv
// Servo position ramp generator: speed-limited or timed Q8 ramp of a servo angle.
// Top level; depends on srp_pkg, srp_cmd_if, srp_rsp_if, srp_ctrl and srp_dp.
//
// Usage:
//   Events arrive as beats on the cmd channel (opcode, estop_active); results leave as
//   beats on the rsp channel (position_deg, error_deg, running, target_reached,
//   start_accepted). Ticks, run start/stop/estop and apply give at most one result
//   beat each; a tick while no run is active and opcodes 5 to 7 give none.
//   Configuration is written through cfg_we / cfg_idx / cfg_wdata, one register per cycle,
//   no read-back; the user must do so only while the block is idle; it is not checked.
// Event flow:
//   The block takes one event at a time. A stop, estop, non-moving tick or an apply or
//   start without division passes the exec and result states before rsp.valid rises; a
//   moving tick also passes the move state. An apply or start in timed mode that must
//   move runs the serial 16-bit divider for the Q8 step, one quotient bit per cycle, in
//   the div state. cmd.ready returns in the cycle after the result is loaded into the
//   output register; a silent event returns from the exec state straight to idle.
// Reset and stall:
//   rst_n clears the run, sets the angle and target to 90 degrees and restores the
//   configuration defaults. A result waits in the output register while rsp.ready is
//   low; the block may take the next event meanwhile and holds its own result until
//   the register is free.
`timescale 1ns / 1ps
`default_nettype none

module servo_position_ramp
    import srp_pkg::*;
#(
    parameter int ANGLE_MAX = ANGLE_MAX_DEF,
    parameter int STEP_MAX  = STEP_MAX_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    srp_cmd_if.sink                    cmd,
    srp_rsp_if.source                  rsp
);
    // Command and status between the sequencer and the datapath.
    srp_ctl_t ctl;
    srp_sts_t sts;

    srp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    srp_dp #(
        .ANGLE_MAX (ANGLE_MAX),
        .STEP_MAX  (STEP_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .in_opcode    (cmd.opcode),
        .in_estop     (cmd.estop_active),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_position (rsp.position_deg),
        .out_error    (rsp.error_deg),
        .out_running  (rsp.running),
        .out_reached  (rsp.target_reached),
        .out_accepted (rsp.start_accepted),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule

`default_nettype wire
